@@ rtl/spiking_neuron_population_update_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the neuron population update core
// Immediate-consequence and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef SPIKING_NEURON_POPULATION_UPDATE_CORE_MACROS_SVH
`define SPIKING_NEURON_POPULATION_UPDATE_CORE_MACROS_SVH

// ante implies cons in the same cycle
`define SNPU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("snpu assertion failed");

// ante implies cons in the next cycle
`define SNPU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("snpu assertion failed");

`endif

@@ rtl/snpu_pkg.sv @@
// ----------------------------------------------------------------------------
// snpu_pkg
// Shared constants and types of the neuron population update core.
// ----------------------------------------------------------------------------
package snpu_pkg;

    localparam int NEURON_COUNT_DEF = 1024;
    localparam int QUEUE_DEPTH      = 4;

    localparam int IDX_W   = 10;
    localparam int PARAM_W = 24;
    localparam int VAL_W   = 32;
    localparam int THR_W   = 23;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_REST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    localparam logic [PARAM_W-1:0] REST_RESET   = 24'hBF0000;   // -65.0
    localparam logic [THR_W-1:0]   THRESH_RESET = 23'h1E0000;   // 30.0

    localparam logic [15:0]       COEF_SQ   = 16'd41943;       // 0.04 in Q0.20
    localparam logic signed [39:0] CONST_140 = 40'sd9175040;

    typedef struct packed {
        logic               action;
        logic [IDX_W-1:0]   neuron;
        logic [PARAM_W-1:0] rate_a;
        logic [PARAM_W-1:0] sensitivity_b;
        logic [PARAM_W-1:0] reset_c;
        logic [PARAM_W-1:0] jump_d;
        logic [VAL_W-1:0]   input_current;
        logic [VAL_W-1:0]   load_u;
    } item_t;

    typedef struct packed {
        logic hazard_stall;
        logic issue;
    } back_status_t;

endpackage

@@ rtl/snpu_if.sv @@
// ----------------------------------------------------------------------------
// snpu channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface snpu_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [9:0]         neuron;
    logic signed [23:0] rate_a;
    logic signed [23:0] sensitivity_b;
    logic signed [23:0] reset_c;
    logic signed [23:0] jump_d;
    logic signed [31:0] input_current;

    modport source (output valid, action, neuron, rate_a, sensitivity_b, reset_c,
                    jump_d, input_current, input ready);
    modport sink   (input valid, action, neuron, rate_a, sensitivity_b, reset_c,
                    jump_d, input_current, output ready);
endinterface

interface snpu_out_if;
    logic               valid;
    logic               ready;
    logic [9:0]         neuron_out;
    logic               fired;
    logic signed [31:0] peak_potential;
    logic signed [31:0] potential;
    logic signed [31:0] recovery;

    modport source (output valid, neuron_out, fired, peak_potential, potential,
                    recovery, input ready);
    modport sink   (input valid, neuron_out, fired, peak_potential, potential,
                    recovery, output ready);
endinterface

interface snpu_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/spiking_neuron_population_update_core.sv @@
// ----------------------------------------------------------------------------
// spiking_neuron_population_update_core
// Time-multiplexed Izhikevich neuron population, Q16.16 arithmetic.
// ----------------------------------------------------------------------------
// Takes one item per cycle while the queue is not full and returns one result
// per item, in order. A step for a neuron whose previous update is still in
// the 8-stage back pipeline waits at the queue head until that update is
// written back to the state memory; items for different neurons flow at full
// rate when the output is not stalled. Neuron memories hold nothing after
// reset until a load item writes them; there is no clearing pass.
`include "spiking_neuron_population_update_core_macros.svh"

module spiking_neuron_population_update_core #(
    parameter int NEURON_COUNT = snpu_pkg::NEURON_COUNT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    snpu_in_if.sink      item,
    snpu_out_if.source   result,
    snpu_cfg_if.sink     cfg
);

    localparam int AW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
    localparam int QW = $bits(snpu_pkg::item_t) + AW;

    logic [23:0] rest_reg;
    logic [22:0] thresh_reg;

    logic                   q_push, q_full, q_pop, q_not_empty;
    snpu_pkg::item_t        f_item, h_item;
    logic [AW-1:0]          f_addr, h_addr;
    logic [QW-1:0]          q_head;
    snpu_pkg::back_status_t status;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg   <= snpu_pkg::REST_RESET;
            thresh_reg <= snpu_pkg::THRESH_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                snpu_pkg::REG_REST:   rest_reg   <= cfg.data;
                snpu_pkg::REG_THRESH: thresh_reg <= cfg.data[22:0];
                default: ;
            endcase
        end
    end

    snpu_front #(.NEURON_COUNT(NEURON_COUNT), .AW(AW)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item),
        .rest_potential (rest_reg),
        .push           (q_push),
        .push_item      (f_item),
        .push_addr      (f_addr),
        .full           (q_full)
    );

    snpu_queue #(.WIDTH(QW), .DEPTH(snpu_pkg::QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_item, f_addr}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_head),
        .not_empty (q_not_empty)
    );

    assign h_item = q_head[QW-1:AW];
    assign h_addr = q_head[AW-1:0];

    snpu_back #(.NEURON_COUNT(NEURON_COUNT), .AW(AW)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (q_not_empty),
        .head_item       (h_item),
        .head_addr       (h_addr),
        .pop             (q_pop),
        .spike_threshold (thresh_reg),
        .rest_potential  (rest_reg),
        .result          (result),
        .status          (status)
    );

    `SNPU_ASSERT_NOW(a_issue_from_queue, clk, rst_n, status.issue, q_not_empty)
    `SNPU_ASSERT_NOW(a_hazard_blocks, clk, rst_n, status.hazard_stall, !status.issue)
    `SNPU_ASSERT_NEXT(a_hazard_holds, clk, rst_n, status.hazard_stall, q_not_empty)
    `SNPU_ASSERT_NOW(a_stall_no_issue, clk, rst_n, result.valid && !result.ready, !status.issue)

endmodule

@@ rtl/snpu_ram.sv @@
// ----------------------------------------------------------------------------
// snpu_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module snpu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/snpu_queue.sv @@
// ----------------------------------------------------------------------------
// snpu_queue
// Small FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module snpu_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = snpu_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [0:DEPTH-1];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/snpu_front.sv @@
// ----------------------------------------------------------------------------
// snpu_front
// Accepts items, maps the neuron to a memory address, precomputes load recovery.
// ----------------------------------------------------------------------------
module snpu_front #(
    parameter int NEURON_COUNT = snpu_pkg::NEURON_COUNT_DEF,
    parameter int AW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    snpu_in_if.sink              item,
    input  logic [23:0]          rest_potential,
    output logic                 push,
    output snpu_pkg::item_t      push_item,
    output logic [AW-1:0]        push_addr,
    input  logic                 full
);

    logic            valid_reg, valid_next;
    snpu_pkg::item_t item_reg;
    logic [AW-1:0]   addr_reg;
    logic [AW-1:0]   addr_calc;
    logic            accept;
    logic signed [47:0] bu;

    assign item.ready = !valid_reg || !full;
    assign accept     = item.valid && item.ready;
    assign push       = valid_reg && !full;
    assign push_item  = item_reg;
    assign push_addr  = addr_reg;

    // b * rest, floor shift by 16 always fits 32 bits
    assign bu = item.sensitivity_b * $signed(rest_potential);

    generate
        if (NEURON_COUNT >= 1024)
        begin : g_direct
            assign addr_calc = AW'(item.neuron);
        end
        else
        begin : g_mod
            // modulo through a reciprocal, exact for 10-bit indexes
            localparam int RECIP = ((1 << 21) + NEURON_COUNT - 1) / NEURON_COUNT;
            logic [31:0] prod;
            logic [9:0]  quot;
            logic [19:0] qn;
            logic [9:0]  rem;
            assign prod = {22'd0, item.neuron} * 32'(RECIP);
            assign quot = prod[30:21];
            assign qn   = {10'd0, quot} * 20'(NEURON_COUNT);
            assign rem  = item.neuron - qn[9:0];
            assign addr_calc = AW'(rem);
        end
    endgenerate

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.action        <= item.action;
            item_reg.neuron        <= item.neuron;
            item_reg.rate_a        <= item.rate_a;
            item_reg.sensitivity_b <= item.sensitivity_b;
            item_reg.reset_c       <= item.reset_c;
            item_reg.jump_d        <= item.jump_d;
            item_reg.input_current <= item.input_current;
            item_reg.load_u        <= bu[47:16];
            addr_reg               <= addr_calc;
        end
    end

endmodule

@@ rtl/snpu_back.sv @@
// ----------------------------------------------------------------------------
// snpu_back
// Memory read, arithmetic pipeline, writeback and output register.
// ----------------------------------------------------------------------------
module snpu_back #(
    parameter int NEURON_COUNT = snpu_pkg::NEURON_COUNT_DEF,
    parameter int AW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  snpu_pkg::item_t        head_item,
    input  logic [AW-1:0]          head_addr,
    output logic                   pop,
    input  logic [22:0]            spike_threshold,
    input  logic [23:0]            rest_potential,
    snpu_out_if.source             result,
    output snpu_pkg::back_status_t status
);

    localparam int NS = 8;

    typedef struct packed {
        logic        action;
        logic [9:0]  neuron;
        logic [23:0] rate_a;
        logic [23:0] sensitivity_b;
        logic [23:0] reset_c;
        logic [23:0] jump_d;
        logic [31:0] load_u;
        logic        fired;
        logic [31:0] peak;
    } pipe_t;

    function automatic logic [31:0] sat32(input logic signed [63:0] x);
        logic [31:0] r;
        if (x > 64'sd2147483647)
        begin
            r = 32'h7FFFFFFF;
        end
        else if (x < -64'sd2147483648)
        begin
            r = 32'h80000000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    logic [NS-1:0] valid_reg;
    pipe_t         ctl_reg  [0:NS-1];
    logic [AW-1:0] addr_reg [0:NS-1];
    logic          out_valid_reg;
    logic          adv;
    logic          hit;
    logic          hazard;
    logic          issue;

    logic [63:0] st_rd;
    logic [95:0] par_rd;
    logic        st_we, par_we;

    logic [31:0] cur0_reg;
    logic [31:0] v1_reg, u1_reg, cur1_reg;
    logic [63:0] sqr2_reg;
    logic signed [39:0] lin2_reg, lin3_reg;
    logic [31:0] u2_reg, u3_reg, u4_reg, u5_reg, u6_reg, u7_reg;
    logic [63:0] prod3_reg;
    logic [31:0] nv4_reg, nv5_reg, nv6_reg, nv7_reg;
    logic signed [55:0] bnv5_reg;
    logic signed [40:0] diff6_reg;
    logic signed [64:0] pr7_reg;

    pipe_t       ctl1;
    logic [31:0] v0, u0, v1, u1;
    logic        fire;
    logic signed [32:0] ud;
    logic signed [63:0] sq_full;
    logic signed [39:0] lin;
    logic [63:0] prod;
    logic signed [47:0] vsum;
    logic signed [55:0] bnv;
    logic signed [40:0] diff;
    logic signed [64:0] pr;
    logic signed [49:0] usum;
    logic [31:0] nv_f, nu_f;

    logic [9:0]  out_neuron_reg;
    logic        out_fired_reg;
    logic [31:0] out_peak_reg, out_v_reg, out_u_reg;

    assign adv = !out_valid_reg || result.ready;

    // a step must not read a neuron whose update is still in the pipeline
    always_comb
    begin
        hit = 1'b0;
        for (int k = 0; k < NS; k++)
        begin
            if (valid_reg[k] && (addr_reg[k] == head_addr))
            begin
                hit = 1'b1;
            end
        end
    end

    assign hazard = head_valid && (head_item.action == snpu_pkg::ACT_STEP) && hit;
    assign issue  = head_valid && adv && !hazard;
    assign pop    = issue;
    assign status.hazard_stall = hazard;
    assign status.issue        = issue;

    assign st_we  = valid_reg[NS-1] && adv;
    assign par_we = st_we && (ctl_reg[NS-1].action == snpu_pkg::ACT_LOAD);

    snpu_ram #(.WIDTH(64), .DEPTH(NEURON_COUNT), .AW(AW)) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (addr_reg[NS-1]),
        .wdata ({nv_f, nu_f}),
        .re    (issue),
        .raddr (head_addr),
        .rdata (st_rd)
    );

    snpu_ram #(.WIDTH(96), .DEPTH(NEURON_COUNT), .AW(AW)) u_param_ram (
        .clk   (clk),
        .we    (par_we),
        .waddr (addr_reg[NS-1]),
        .wdata ({ctl_reg[NS-1].rate_a, ctl_reg[NS-1].sensitivity_b,
                 ctl_reg[NS-1].reset_c, ctl_reg[NS-1].jump_d}),
        .re    (issue),
        .raddr (head_addr),
        .rdata (par_rd)
    );

    // stage 1: spike test and after-spike reset
    always_comb
    begin
        ctl1 = ctl_reg[0];
        v0   = st_rd[63:32];
        u0   = st_rd[31:0];
        if (ctl_reg[0].action == snpu_pkg::ACT_STEP)
        begin
            ctl1.rate_a        = par_rd[95:72];
            ctl1.sensitivity_b = par_rd[71:48];
            ctl1.reset_c       = par_rd[47:24];
            ctl1.jump_d        = par_rd[23:0];
        end
        fire = (ctl_reg[0].action == snpu_pkg::ACT_STEP)
            && ($signed(v0) >= $signed({9'd0, spike_threshold}));
        ud = $signed({u0[31], u0}) + $signed({{9{ctl1.jump_d[23]}}, ctl1.jump_d});
        v1 = fire ? {{8{ctl1.reset_c[23]}}, ctl1.reset_c} : v0;
        u1 = fire ? sat32({{31{ud[32]}}, ud}) : u0;
        ctl1.fired = fire;
        ctl1.peak  = fire ? v0 : '0;
    end

    // stage 2: square and the linear terms
    assign sq_full = $signed(v1_reg) * $signed(v1_reg);
    assign lin = $signed({{8{v1_reg[31]}}, v1_reg}) * 40'sd6 + snpu_pkg::CONST_140
               - $signed({{8{u1_reg[31]}}, u1_reg})
               + $signed({{8{cur1_reg[31]}}, cur1_reg});

    // stage 3: scale the square by 0.04
    assign prod = sqr2_reg[63:16] * snpu_pkg::COEF_SQ;

    // stage 4: new potential
    assign vsum = $signed({4'd0, prod3_reg[63:20]}) + $signed({{8{lin3_reg[39]}}, lin3_reg});

    // stages 5..7: recovery update
    assign bnv  = $signed(ctl_reg[4].sensitivity_b) * $signed(nv4_reg);
    assign diff = $signed({bnv5_reg[55], bnv5_reg[55:16]}) - $signed({{9{u5_reg[31]}}, u5_reg});
    assign pr   = $signed(ctl_reg[6].rate_a) * diff6_reg;
    assign usum = $signed({pr7_reg[64], pr7_reg[64:16]}) + $signed({{18{u7_reg[31]}}, u7_reg});

    always_comb
    begin
        if (ctl_reg[NS-1].action == snpu_pkg::ACT_LOAD)
        begin
            nv_f = {{8{rest_potential[23]}}, rest_potential};
            nu_f = ctl_reg[NS-1].load_u;
        end
        else
        begin
            nv_f = nv7_reg;
            nu_f = sat32({{14{usum[49]}}, usum});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[NS-2:0], issue};
            out_valid_reg <= valid_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0].action        <= head_item.action;
            ctl_reg[0].neuron        <= head_item.neuron;
            ctl_reg[0].rate_a        <= head_item.rate_a;
            ctl_reg[0].sensitivity_b <= head_item.sensitivity_b;
            ctl_reg[0].reset_c       <= head_item.reset_c;
            ctl_reg[0].jump_d        <= head_item.jump_d;
            ctl_reg[0].load_u        <= head_item.load_u;
            ctl_reg[0].fired         <= 1'b0;
            ctl_reg[0].peak          <= '0;
            addr_reg[0]              <= head_addr;
            cur0_reg                 <= head_item.input_current;

            ctl_reg[1] <= ctl1;
            for (int k = 2; k < NS; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
            for (int k = 1; k < NS; k++)
            begin
                addr_reg[k] <= addr_reg[k-1];
            end

            v1_reg   <= v1;
            u1_reg   <= u1;
            cur1_reg <= cur0_reg;

            sqr2_reg <= sq_full;
            lin2_reg <= lin;
            u2_reg   <= u1_reg;

            prod3_reg <= prod;
            lin3_reg  <= lin2_reg;
            u3_reg    <= u2_reg;

            nv4_reg <= sat32({{16{vsum[47]}}, vsum});
            u4_reg  <= u3_reg;

            bnv5_reg <= bnv;
            nv5_reg  <= nv4_reg;
            u5_reg   <= u4_reg;

            diff6_reg <= diff;
            nv6_reg   <= nv5_reg;
            u6_reg    <= u5_reg;

            pr7_reg <= pr;
            nv7_reg <= nv6_reg;
            u7_reg  <= u6_reg;

            out_neuron_reg <= ctl_reg[NS-1].neuron;
            out_fired_reg  <= ctl_reg[NS-1].fired;
            out_peak_reg   <= ctl_reg[NS-1].peak;
            out_v_reg      <= nv_f;
            out_u_reg      <= nu_f;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.neuron_out     = out_neuron_reg;
    assign result.fired          = out_fired_reg;
    assign result.peak_potential = out_peak_reg;
    assign result.potential      = out_v_reg;
    assign result.recovery       = out_u_reg;

endmodule

@@ sim/snpu_tb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench interface file
// The block's channel interfaces live with the RTL; this file holds the
// testbench package with the neuron_update_t result record.
// ----------------------------------------------------------------------------
package snpu_tb_pkg;

    typedef struct {
        logic [snpu_pkg::IDX_W-1:0] neuron;
        logic                       fired;
        logic signed [31:0]         peak;
        logic signed [31:0]         potential;
        logic signed [31:0]         recovery;
    } neuron_update_t;
endpackage

@@ sim/spiking_neuron_population_update_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Izhikevich population core testbench
// Drives load and step transactions with random idling on both channels,
// predicts each update in Q16.16 and checks results in order.
// ----------------------------------------------------------------------------

class neuron_scoreboard;
    logic signed [31:0] pot_q [1024];
    logic signed [31:0] rec_q [1024];
    logic signed [23:0] a_q [1024];
    logic signed [23:0] b_q [1024];
    logic signed [23:0] c_q [1024];
    logic signed [23:0] d_q [1024];
    logic signed [23:0] rest_level;
    logic [22:0]        fire_level;
    snpu_tb_pkg::neuron_update_t pending [$];
    int                 errors;
    int                 checked;
    int                 spikes;

    function new();
        rest_level = snpu_pkg::REST_RESET;
        fire_level = snpu_pkg::THRESH_RESET;
        errors = 0;
        checked = 0;
        spikes = 0;
    endfunction

    function automatic logic signed [31:0] clip32(logic signed [127:0] x);
        if (x > 128'sd2147483647)
            return 32'sh7fffffff;
        if (x < -128'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    function void report(string what, logic [31:0] exp_val, logic [31:0] got_val);
        errors++;
        if (errors <= 30)
            $display("MISMATCH %s: expected %h got %h (result %0d)", what, exp_val,
                     got_val, checked);
    endfunction

    function void note_item(logic act, logic [9:0] idx, logic signed [23:0] ra,
                            logic signed [23:0] sb, logic signed [23:0] rc,
                            logic signed [23:0] jd, logic signed [31:0] cur);
        snpu_tb_pkg::neuron_update_t e;
        logic signed [127:0] v, u, sq, nv, du;
        e.neuron = idx;
        e.fired = 1'b0;
        e.peak = '0;
        if (act == snpu_pkg::ACT_LOAD) begin
            a_q[idx] = ra;
            b_q[idx] = sb;
            c_q[idx] = rc;
            d_q[idx] = jd;
            e.potential = rest_level;
            e.recovery = clip32((128'(sb) * 128'(rest_level)) >>> 16);
        end
        else begin
            v = pot_q[idx];
            u = rec_q[idx];
            if (v >= $signed({1'b0, fire_level})) begin
                e.fired = 1'b1;
                e.peak = v[31:0];
                v = 128'(c_q[idx]);
                u = clip32(u + 128'(d_q[idx]));
            end
            sq = (((v * v) >>> 16) * 128'sd41943) >>> 20;
            nv = clip32(v + sq + 5 * v + 128'sd9175040 - u + 128'(cur));
            du = (128'(a_q[idx]) * (((128'(b_q[idx]) * nv) >>> 16) - u)) >>> 16;
            e.potential = nv[31:0];
            e.recovery = clip32(u + du);
        end
        pot_q[idx] = e.potential;
        rec_q[idx] = e.recovery;
        pending.push_back(e);
    endfunction

    function void check_result(snpu_tb_pkg::neuron_update_t got);
        snpu_tb_pkg::neuron_update_t e;
        checked++;
        if (got.fired)
            spikes++;
        if (pending.size() == 0) begin
            report("unexpected result", 0, got.neuron);
            return;
        end
        e = pending.pop_front();
        if (got.neuron !== e.neuron)
            report("neuron_out", e.neuron, got.neuron);
        if (got.fired !== e.fired)
            report("fired", e.fired, got.fired);
        if (got.peak !== e.peak)
            report("peak_potential", e.peak, got.peak);
        if (got.potential !== e.potential)
            report("potential", e.potential, got.potential);
        if (got.recovery !== e.recovery)
            report("recovery", e.recovery, got.recovery);
    endfunction
endclass

module spiking_neuron_population_update_core_test;
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   src_idle = 27;
    int   dst_idle = 62;
    int   items_sent = 0;
    int   loads_sent = 0;
    bit   loaded [1024];
    neuron_scoreboard board;

    snpu_in_if  item_ch ();
    snpu_out_if result_ch ();
    snpu_cfg_if cfg_ch ();

    spiking_neuron_population_update_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #1 clk = ~clk;

    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stall, check on each accepted transaction.
    always @(posedge clk)
    begin
        snpu_tb_pkg::neuron_update_t got;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            got.neuron = result_ch.neuron_out;
            got.fired = result_ch.fired;
            got.peak = result_ch.peak_potential;
            got.potential = result_ch.potential;
            got.recovery = result_ch.recovery;
            board.check_result(got);
        end
        result_ch.ready <= rst_n && ($urandom_range(99) >= dst_idle);
    end

    // valid stays high after acceptance until a later call idles or drain() runs
    task automatic send_item(logic act, logic [9:0] idx, logic signed [23:0] ra,
                             logic signed [23:0] sb, logic signed [23:0] rc,
                             logic signed [23:0] jd, logic signed [31:0] cur);
        while ($urandom_range(99) < src_idle) begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.action <= act;
        item_ch.neuron <= idx;
        item_ch.rate_a <= ra;
        item_ch.sensitivity_b <= sb;
        item_ch.reset_c <= rc;
        item_ch.jump_d <= jd;
        item_ch.input_current <= cur;
        do
            @(posedge clk);
        while (!item_ch.ready);
        board.note_item(act, idx, ra, sb, rc, jd, cur);
        if (act == snpu_pkg::ACT_LOAD) begin
            loaded[idx] = 1'b1;
            loads_sent++;
        end
        items_sent++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == snpu_pkg::REG_REST)
            board.rest_level = value;
        else
            board.fire_level = value[22:0];
        @(posedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        item_ch.valid <= 1'b0;
        while (board.pending.size() != 0 && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        repeat (30) @(posedge clk);
    endtask

    // Typical regular-spiking parameters with some random spread.
    task automatic load_typical(logic [9:0] idx);
        send_item(snpu_pkg::ACT_LOAD, idx, 24'sd1311 + $signed(24'($urandom_range(2000))),
                  24'sd13107 + $signed(24'($urandom_range(3000))),
                  -24'sd4259840 + $signed(24'($urandom_range(1000000))),
                  24'sd131072 + $signed(24'($urandom_range(400000))), '0);
    endtask

    task automatic random_phase(int count);
        int k;
        logic [9:0] idx;
        for (k = 0; k < count; k++) begin
            idx = 10'($urandom_range(15)) | (($urandom_range(3) == 0) ?
                                              10'($urandom) : 10'd0);
            case ($urandom_range(9))
                0:
                    send_item(snpu_pkg::ACT_LOAD, idx, 24'($urandom), 24'($urandom),
                              24'($urandom), 24'($urandom), 32'($urandom));
                1, 2:
                    load_typical(idx);
                default:
                    if (loaded[idx])
                        send_item(snpu_pkg::ACT_STEP, idx, 24'($urandom), 24'($urandom),
                                  24'($urandom), 24'($urandom),
                                  ($urandom_range(7) == 0) ? 32'($urandom) :
                                  32'($urandom_range(1500000)));
                    else
                        load_typical(idx);
            endcase
        end
    endtask

    initial
    begin
        board = new();
        item_ch.valid = 1'b0;
        item_ch.action = snpu_pkg::ACT_LOAD;
        item_ch.neuron = '0;
        item_ch.rate_a = '0;
        item_ch.sensitivity_b = '0;
        item_ch.reset_c = '0;
        item_ch.jump_d = '0;
        item_ch.input_current = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = snpu_pkg::REG_REST;
        cfg_ch.data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, both actions, spikes, back-to-back same neuron.
        send_item(snpu_pkg::ACT_LOAD, 10'd0, 24'sh7fffff, 24'sh800000, 24'sh7fffff,
                  24'sh800000, '0);
        send_item(snpu_pkg::ACT_LOAD, 10'd1023, 24'sh800000, 24'sh7fffff, 24'sh800000,
                  24'sh7fffff, '0);
        send_item(snpu_pkg::ACT_STEP, 10'd0, '0, '0, '0, '0, 32'sh7fffffff);
        send_item(snpu_pkg::ACT_STEP, 10'd0, '0, '0, '0, '0, 32'sh80000000);
        send_item(snpu_pkg::ACT_STEP, 10'd0, '0, '0, '0, '0, 32'sh7fffffff);
        send_item(snpu_pkg::ACT_STEP, 10'd1023, '0, '0, '0, '0, 32'sh7fffffff);
        send_item(snpu_pkg::ACT_STEP, 10'd1023, '0, '0, '0, '0, '0);
        load_typical(10'd5);
        send_item(snpu_pkg::ACT_STEP, 10'd5, '0, '0, '0, '0, 32'sh01000000);
        send_item(snpu_pkg::ACT_STEP, 10'd5, '0, '0, '0, '0, 32'sh01000000);
        send_item(snpu_pkg::ACT_STEP, 10'd5, '0, '0, '0, '0, '0);
        send_item(snpu_pkg::ACT_STEP, 10'd5, '0, '0, '0, '0, -32'sd5);
        drain();

        write_reg(snpu_pkg::REG_REST, 24'sh7fffff);
        write_reg(snpu_pkg::REG_THRESH, 23'd0);
        send_item(snpu_pkg::ACT_LOAD, 10'd2, 24'sd1311, 24'sh7fffff, 24'sd0, 24'sh7fffff, '0);
        send_item(snpu_pkg::ACT_STEP, 10'd2, '0, '0, '0, '0, '0);
        send_item(snpu_pkg::ACT_STEP, 10'd2, '0, '0, '0, '0, '0);
        drain();
        write_reg(snpu_pkg::REG_REST, 24'sh800000);
        write_reg(snpu_pkg::REG_THRESH, 23'h7fffff);
        send_item(snpu_pkg::ACT_LOAD, 10'd3, 24'sd1311, 24'sh7fffff, 24'sd0, 24'sd0, '0);
        send_item(snpu_pkg::ACT_STEP, 10'd3, '0, '0, '0, '0, 32'sh7fffffff);
        drain();
        write_reg(snpu_pkg::REG_REST, snpu_pkg::REST_RESET);
        write_reg(snpu_pkg::REG_THRESH, snpu_pkg::THRESH_RESET);

        random_phase(500);
        drain();
        src_idle = 62;
        dst_idle = 27;
        write_reg(snpu_pkg::REG_THRESH, 23'($urandom));
        write_reg(snpu_pkg::REG_REST, 24'($urandom));
        random_phase(450);
        drain();
        src_idle = 0;
        dst_idle = 0;
        write_reg(snpu_pkg::REG_REST, snpu_pkg::REST_RESET);
        write_reg(snpu_pkg::REG_THRESH, snpu_pkg::THRESH_RESET);
        random_phase(480);
        drain();

        $display("Sent %0d transactions (%0d loads), checked %0d results, %0d spikes.",
                 items_sent, loads_sent, board.checked, board.spikes);
        if (board.pending.size() != 0)
            board.report("results missing", board.pending.size(), 0);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/snpu_pkg.sv
rtl/snpu_if.sv
rtl/snpu_ram.sv
rtl/snpu_queue.sv
rtl/snpu_front.sv
rtl/snpu_back.sv
rtl/spiking_neuron_population_update_core.sv
sim/snpu_tb_if.sv
sim/spiking_neuron_population_update_core_test.sv
